// ===== rtl/core/ssrc_pkg.sv =====
// Shared types, constants and codes for the stepper speed ramp controller.
package ssrc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int DB_W        = 12;
    localparam int HZ_W        = 16;
    localparam int RATE_W      = 17;
    localparam int EXT_W       = 18;
    localparam int PERIOD_W    = 20;
    localparam int CMP_W       = 19;
    localparam int PROD_W      = SAMPLE_BITS + HZ_W;
    localparam int DEN_W       = HZ_W;
    localparam int MAP_W       = PROD_W + 2;
    localparam int US_PER_S    = 1000000;
    localparam int PERIOD_MIN  = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        FUNC_THROTTLE = 2'd0,
        FUNC_SET      = 2'd1,
        FUNC_TICK     = 2'd2,
        FUNC_STOP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_DEADBAND  = 2'd0,
        REG_MIN_RATE  = 2'd1,
        REG_MAX_RATE  = 2'd2,
        REG_RAMP_STEP = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_MAP,
        OP_ZERO_TICK,
        OP_SET,
        OP_TICK,
        OP_STOP
    } op_t;

    typedef struct packed {
        logic [DB_W-1:0] deadband;
        logic [HZ_W-1:0] min_rate;
        logic [HZ_W-1:0] max_rate;
        logic [HZ_W-1:0] ramp_step;
    } cfg_t;

    typedef struct packed {
        op_t                      op;
        logic [SAMPLE_BITS-1:0]   sample;
        logic                     ccw;
        logic signed [RATE_W-1:0] target;
    } cmd_t;

endpackage

// ===== rtl/core/ssrc_front.sv =====
// Front end: accepts command words and classifies them for the back end.
module ssrc_front
    import ssrc_pkg::*;
(
    input  logic                     in_valid,
    input  logic [1:0]               func,
    input  logic [SAMPLE_BITS-1:0]   cw_sample,
    input  logic [SAMPLE_BITS-1:0]   ccw_sample,
    input  logic signed [RATE_W-1:0] direct_target_hz,
    input  cfg_t                     cfg,
    input  logic                     q_full,
    output logic                     in_stall,
    output logic                     push,
    output cmd_t                     cmd
);

    logic                     cw_on;
    logic                     ccw_on;
    logic signed [RATE_W-1:0] mx;

    assign cw_on  = RATE_W'(cw_sample) > RATE_W'(cfg.deadband);
    assign ccw_on = RATE_W'(ccw_sample) > RATE_W'(cfg.deadband);
    assign mx     = $signed({1'b0, cfg.max_rate});

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.sample = cw_on ? cw_sample : ccw_sample;
        cmd.ccw    = !cw_on;
        cmd.target = direct_target_hz;
        if (direct_target_hz > mx)
        begin
            cmd.target = mx;
        end
        else if (direct_target_hz < -mx)
        begin
            cmd.target = -mx;
        end
        case (func_t'(func))
            FUNC_THROTTLE: cmd.op = (cw_on != ccw_on) ? OP_MAP : OP_ZERO_TICK;
            FUNC_SET:      cmd.op = OP_SET;
            FUNC_TICK:     cmd.op = OP_TICK;
            FUNC_STOP:     cmd.op = OP_STOP;
            default:       cmd.op = OP_STOP;
        endcase
    end

endmodule

// ===== rtl/core/ssrc_fifo.sv =====
// Short command queue between the front and back ends.
module ssrc_fifo
    import ssrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign full  = count_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/ssrc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module ssrc_div
    import ssrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [PROD_W-1:0] quo
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W+1:0]  rem_sh;
    logic [DEN_W+1:0]  rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_sub = rem_sh - (DEN_W + 2)'(den_reg);
    assign done    = done_reg;
    assign quo     = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[DEN_W+1])
            begin
                rem_reg <= rem_sub[DEN_W:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DEN_W:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/core/ssrc_back.sv =====
// Back end: throttle map, ramp tick, period derivation and result register.
module ssrc_back
    import ssrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       q_empty,
    input  cmd_t                       q_head,
    output logic                       pop,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [RATE_W-1:0]   current_rate,
    output logic signed [RATE_W-1:0]   target_rate,
    output logic                       direction_cw,
    output logic                       step_enable,
    output logic [PERIOD_W-1:0]        step_period,
    output logic [PERIOD_W-1:0]        reload_value,
    output logic [CMP_W-1:0]           compare_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAPGO,
        ST_MAPDIV,
        ST_TICK,
        ST_PERDIV,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [RATE_W-1:0] cur_reg, cur_next;
    logic signed [RATE_W-1:0] tgt_reg, tgt_next;
    logic                     dir_reg, dir_next;
    logic [PERIOD_W-1:0]      per_reg, per_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     negmap_reg, negmap_next;
    logic                     ov_reg, ov_next;
    logic signed [RATE_W-1:0] rcur_reg, rcur_next;
    logic signed [RATE_W-1:0] rtgt_reg, rtgt_next;
    logic                     rdir_reg, rdir_next;
    logic [PERIOD_W-1:0]      rper_reg, rper_next;

    logic                     div_start;
    logic [PROD_W-1:0]        div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quo;

    logic [RATE_W-1:0]        span_w;
    logic [RATE_W-1:0]        diff_w;
    logic signed [RATE_W-1:0] hl;
    logic [HZ_W-1:0]          hl_mag;
    logic signed [MAP_W-1:0]  sq;
    logic signed [MAP_W-1:0]  fmap;
    logic signed [MAP_W-1:0]  lo_ext;
    logic signed [MAP_W-1:0]  hi_ext;
    logic [HZ_W-1:0]          mapped;

    logic signed [RATE_W-1:0] tz;
    logic signed [EXT_W-1:0]  delta;
    logic signed [EXT_W-1:0]  step_ext;
    logic signed [EXT_W-1:0]  cnew_ext;
    logic signed [RATE_W-1:0] cnew;
    logic [HZ_W-1:0]          cmag;

    ssrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign span_w = RATE_W'(FULL_SCALE) - RATE_W'(cfg.deadband);
    assign diff_w = RATE_W'(cmd_reg.sample) - RATE_W'(cfg.deadband);
    assign hl     = $signed({1'b0, cfg.max_rate}) - $signed({1'b0, cfg.min_rate});
    assign hl_mag = hl[RATE_W-1] ? HZ_W'(-hl) : HZ_W'(hl);
    assign lo_ext = $signed(MAP_W'(cfg.min_rate));
    assign hi_ext = $signed(MAP_W'(cfg.max_rate));
    assign sq     = negmap_reg ? -$signed(MAP_W'(div_quo)) : $signed(MAP_W'(div_quo));
    assign fmap   = lo_ext + sq;

    always_comb
    begin
        if (fmap < lo_ext)
        begin
            mapped = cfg.min_rate;
        end
        else if (fmap > hi_ext)
        begin
            mapped = cfg.max_rate;
        end
        else
        begin
            mapped = fmap[HZ_W-1:0];
        end
    end

    // A target of the opposite sign to a moving rate is dropped to zero first.
    assign tz = ((tgt_reg > 0 && cur_reg < 0) || (tgt_reg < 0 && cur_reg > 0)) ? '0 : tgt_reg;
    assign delta    = EXT_W'(tz) - EXT_W'(cur_reg);
    assign step_ext = $signed(EXT_W'(cfg.ramp_step));

    always_comb
    begin
        cnew_ext = EXT_W'(cur_reg);
        if (delta > 0)
        begin
            cnew_ext = EXT_W'(cur_reg) + ((delta < step_ext) ? delta : step_ext);
        end
        else if (delta < 0)
        begin
            cnew_ext = EXT_W'(cur_reg) + ((delta > -step_ext) ? delta : -step_ext);
        end
    end

    assign cnew = cnew_ext[RATE_W-1:0];
    assign cmag = cnew[RATE_W-1] ? HZ_W'(-cnew) : HZ_W'(cnew);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        dir_next    = dir_reg;
        per_next    = per_reg;
        prod_next   = prod_reg;
        negmap_next = negmap_reg;
        ov_next     = ov_reg && out_stall;
        rcur_next   = rcur_reg;
        rtgt_next   = rtgt_reg;
        rdir_next   = rdir_reg;
        rper_next   = rper_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        div_num     = prod_reg;
        div_den     = span_w[DEN_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                    case (q_head.op)
                        OP_MAP:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_ZERO_TICK:
                        begin
                            tgt_next   = '0;
                            state_next = ST_TICK;
                        end
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                        end
                        OP_SET:
                        begin
                            tgt_next   = q_head.target;
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            tgt_next   = '0;
                            cur_next   = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next   = PROD_W'(diff_w[SAMPLE_BITS-1:0] * hl_mag);
                negmap_next = hl[RATE_W-1];
                state_next  = ST_MAPGO;
            end
            ST_MAPGO:
            begin
                div_start  = 1'b1;
                state_next = ST_MAPDIV;
            end
            ST_MAPDIV:
            begin
                if (div_done)
                begin
                    tgt_next   = cmd_reg.ccw ? -$signed({1'b0, mapped})
                                             : $signed({1'b0, mapped});
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                tgt_next = tz;
                cur_next = cnew;
                if (cnew != '0)
                begin
                    div_start  = 1'b1;
                    div_num    = PROD_W'(US_PER_S);
                    div_den    = cmag;
                    state_next = ST_PERDIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_PERDIV:
            begin
                if (div_done)
                begin
                    dir_next   = cur_reg > 0;
                    per_next   = (div_quo < PROD_W'(PERIOD_MIN)) ? PERIOD_W'(PERIOD_MIN)
                                                                 : div_quo[PERIOD_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    rcur_next  = cur_reg;
                    rtgt_next  = tgt_reg;
                    rdir_next  = dir_reg;
                    rper_next  = per_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            tgt_reg    <= '0;
            dir_reg    <= 1'b1;
            per_reg    <= PERIOD_W'(PERIOD_MIN);
            ov_reg     <= 1'b0;
            cmd_reg    <= '0;
            prod_reg   <= '0;
            negmap_reg <= 1'b0;
            rcur_reg   <= '0;
            rtgt_reg   <= '0;
            rdir_reg   <= 1'b1;
            rper_reg   <= PERIOD_W'(PERIOD_MIN);
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            dir_reg    <= dir_next;
            per_reg    <= per_next;
            ov_reg     <= ov_next;
            cmd_reg    <= cmd_next;
            prod_reg   <= prod_next;
            negmap_reg <= negmap_next;
            rcur_reg   <= rcur_next;
            rtgt_reg   <= rtgt_next;
            rdir_reg   <= rdir_next;
            rper_reg   <= rper_next;
        end
    end

    assign out_valid     = ov_reg;
    assign current_rate  = rcur_reg;
    assign target_rate   = rtgt_reg;
    assign direction_cw  = rdir_reg;
    assign step_enable   = rcur_reg != '0;
    assign step_period   = rper_reg;
    assign reload_value  = rper_reg - 1'b1;
    assign compare_value = CMP_W'(rper_reg >> 1);

    a_period_floor: assert property (@(posedge clk) disable iff (!rst_n)
        per_reg >= PERIOD_W'(PERIOD_MIN))
        else $error("period latch below its floor");

    a_no_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK |=> !((cur_reg > 0 && $past(cur_reg) < 0)
                                || (cur_reg < 0 && $past(cur_reg) > 0)))
        else $error("ramp tick reversed the rate");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_MAPDIV || state_reg == ST_PERDIV))
        else $error("divider finished outside a wait state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(rcur_reg) && $stable(rper_reg))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/stepper_speed_ramp_controller.sv =====
// Top level of the stepper speed ramp controller: registers, queue and both ends.
//
//  channel  direction  handshake              word
//  in       sink       in_valid / in_stall    func, samples, direct target
//  out      source     out_valid / out_stall  rates, direction, timer values
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Stop and set-target words go from the queue straight to the result register; a
// tick passes through the ramp step and, if it leaves the rate moving, through the
// 28-step serial divider for the period. A throttle word with one side past the
// deadband runs the divider for the map first. A four-word queue lets the front
// end accept while the back end works or a result waits. Reset is asynchronous
// and needs no clearing pass; the configuration port is always ready.
module stepper_speed_ramp_controller
    import ssrc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [SAMPLE_BITS-1:0]   cw_sample,
    input  logic [SAMPLE_BITS-1:0]   ccw_sample,
    input  logic signed [RATE_W-1:0] direct_target_hz,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [RATE_W-1:0] current_rate,
    output logic signed [RATE_W-1:0] target_rate,
    output logic                     direction_cw,
    output logic                     step_enable,
    output logic [PERIOD_W-1:0]      step_period,
    output logic [PERIOD_W-1:0]      reload_value,
    output logic [CMP_W-1:0]         compare_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [HZ_W-1:0]          cfg_data
);

    cfg_t cfg_reg;
    cmd_t front_cmd;
    cmd_t q_head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband  <= DB_W'(150);
            cfg_reg.min_rate  <= HZ_W'(200);
            cfg_reg.max_rate  <= HZ_W'(5000);
            cfg_reg.ramp_step <= HZ_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEADBAND:  cfg_reg.deadband  <= cfg_data[DB_W-1:0];
                REG_MIN_RATE:  cfg_reg.min_rate  <= cfg_data;
                REG_MAX_RATE:  cfg_reg.max_rate  <= cfg_data;
                REG_RAMP_STEP: cfg_reg.ramp_step <= cfg_data;
                default:       cfg_reg.ramp_step <= cfg_reg.ramp_step;
            endcase
        end
    end

    ssrc_front u_front (
        .in_valid         (in_valid),
        .func             (func),
        .cw_sample        (cw_sample),
        .ccw_sample       (ccw_sample),
        .direct_target_hz (direct_target_hz),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .in_stall         (in_stall),
        .push             (push),
        .cmd              (front_cmd)
    );

    ssrc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    ssrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .current_rate  (current_rate),
        .target_rate   (target_rate),
        .direction_cw  (direction_cw),
        .step_enable   (step_enable),
        .step_period   (step_period),
        .reload_value  (reload_value),
        .compare_value (compare_value)
    );

endmodule
